FILE: rtl/sync_field_search_core_defines.svh
// Assertion macros for the sync field search RTL.
`ifndef SYNC_FIELD_SEARCH_CORE_DEFINES_SVH
`define SYNC_FIELD_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define SFS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define SFS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sfs_pkg.sv
// Shared types, constants and the byte scoring function of the sync field search.
`default_nettype none
package sfs_pkg;

   localparam int PAT_W       = 256;
   localparam int PAT_WORD_W  = 64;
   localparam int OUT_W       = 17;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int PCT_W       = 7;
   localparam int RUN_BITS    = 8;
   localparam int RUN_W       = 3;
   localparam int PCT_FULL    = 100;
   localparam logic [PCT_W-1:0] PCT_RESET = 7'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_0  = 3'd0,
      REG_PATTERN_1  = 3'd1,
      REG_PATTERN_2  = 3'd2,
      REG_PATTERN_3  = 3'd3,
      REG_CONFIDENCE = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic             is_check;
      logic             last_bit;
      logic [OUT_W-1:0] payload_start;
   } job_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } verdict_type;

   typedef struct packed {
      logic [RUN_W-1:0] run;
      logic             point;
   } step_type;

   // Walk one byte of match flags, most significant first, carrying the run.
   function automatic step_type score_byte(logic [RUN_W-1:0] run_in,
                                           logic [RUN_BITS-1:0] match);
      step_type       res;
      logic [RUN_W:0] run;
      logic           point;
      run   = {1'b0, run_in};
      point = 1'b0;
      for (int j = RUN_BITS - 1; j >= 0; j--) begin
         if (match[j]) begin
            run = run + 1'b1;
            if (run == (RUN_W + 1)'(RUN_BITS)) begin
               point = 1'b1;
               run   = '0;
            end
         end else begin
            run = '0;
         end
      end
      res.run   = run[RUN_W-1:0];
      res.point = point;
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/sfs_front.sv
// Front end: takes bits, keeps the window and frame count, and issues jobs.
`default_nettype none
module sfs_front #(
   parameter int SYNC_BITS      = 256,
   parameter int MAX_FRAME_BITS = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [sfs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tlast,
   output      logic                           push_valid,
   input  wire logic                           push_ready,
   output      sfs_pkg::job_type               push_job,
   input  wire sfs_pkg::verdict_type           verdict,
   output      logic [SYNC_BITS-1:0]           window,
   output      logic                           busy
);
   import sfs_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);

   logic [SYNC_BITS-1:0] window_ff, window_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 done_ff, done_in;
   logic                 busy_ff, busy_in;
   logic                 last_ff, last_in;
   logic                 accept, in_range, check;
   logic [CNT_W-1:0]     count_inc;

   assign req_tready = !busy_ff && push_ready;
   assign accept     = req_tvalid && req_tready;
   assign in_range   = count_ff < CNT_W'(MAX_FRAME_BITS);
   assign count_inc  = count_ff + 1'b1;
   assign check      = in_range && !done_ff && (count_inc >= CNT_W'(SYNC_BITS));

   assign push_valid             = accept && (check || (req_tlast && !done_ff));
   assign push_job.is_check      = check;
   assign push_job.last_bit      = req_tlast;
   assign push_job.payload_start = check ? OUT_W'(count_inc) : '0;

   assign window = window_ff;
   assign busy   = busy_ff;

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      busy_in   = busy_ff;
      last_in   = last_ff;
      if (accept) begin
         if (in_range) begin
            window_in = {window_ff[SYNC_BITS-2:0], req_tdata[0]};
            count_in  = count_inc;
         end
         if (check) begin
            // hold the window until the back end returns its verdict
            busy_in = 1'b1;
            last_in = req_tlast;
         end else if (req_tlast) begin
            count_in = '0;
            done_in  = 1'b0;
         end
      end
      if (verdict.valid) begin
         busy_in = 1'b0;
         done_in = verdict.hit;
         if (last_ff) begin
            count_in = '0;
            done_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
         busy_ff  <= busy_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule
`default_nettype wire

FILE: rtl/sfs_queue.sv
// Two-entry job queue between the front and back ends.
`default_nettype none
module sfs_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output      logic             push_ready,
   input  wire sfs_pkg::job_type push_job,
   output      logic             pop_valid,
   input  wire logic             pop_ready,
   output      sfs_pkg::job_type pop_job
);
   import sfs_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sfs_back.sv
// Back end: scores the window a byte per cycle and drives the result register.
`default_nettype none
module sfs_back #(
   parameter int SYNC_BITS = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           job_valid,
   output      logic                           job_ready,
   input  wire sfs_pkg::job_type               job,
   input  wire logic [SYNC_BITS-1:0]           window,
   input  wire logic [sfs_pkg::PAT_W-1:0]      pattern,
   input  wire logic [sfs_pkg::PCT_W-1:0]      percent,
   output      sfs_pkg::verdict_type           verdict,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [sfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                           rsp_tuser
);
   import sfs_pkg::*;

   localparam int STEPS  = (SYNC_BITS + RUN_BITS - 1) / RUN_BITS;
   localparam int EXT_W  = STEPS * RUN_BITS;
   localparam int PAD    = EXT_W - SYNC_BITS;
   localparam int BYTES  = SYNC_BITS / RUN_BITS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int PTS_W  = $clog2(STEPS + 1);
   localparam int CMP_W  = $clog2((2 ** PCT_W - 1) * STEPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCORE  = 3'b010,
      ST_FINISH = 3'b100
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [EXT_W-1:0] scan_ff, scan_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [PTS_W-1:0] points_ff, points_in;
   logic [STEP_W-1:0] step_ff, step_in;
   job_type          job_ff, job_in;
   logic [CMP_W-1:0] need_ff;
   logic             out_valid_ff, out_valid_in;
   logic             out_found_ff, out_found_in;
   logic [OUT_W-1:0] out_start_ff, out_start_in;
   logic             out_free, hit;
   logic [SYNC_BITS-1:0] match;
   step_type         step_res;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign match      = ~(window ^ pattern[PAT_W-1 -: SYNC_BITS]);
   assign step_res   = score_byte(run_ff, scan_ff[EXT_W-1 -: RUN_BITS]);
   assign hit        = (CMP_W'(points_ff) * CMP_W'(PCT_FULL)) >= need_ff;
   assign job_ready  = (state_ff == ST_IDLE) && out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_start_ff);

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      run_in        = run_ff;
      points_in     = points_ff;
      step_in       = step_ff;
      job_in        = job_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_found_in  = out_found_ff;
      out_start_in  = out_start_ff;
      verdict.valid = 1'b0;
      verdict.hit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid && job_ready) begin
               job_in = job;
               if (job.is_check) begin
                  // pad after the last pattern bit so every step sees a full byte
                  scan_in   = EXT_W'(match) << PAD;
                  run_in    = '0;
                  points_in = '0;
                  step_in   = '0;
                  state_in  = ST_SCORE;
               end else begin
                  out_valid_in = 1'b1;
                  out_found_in = 1'b0;
                  out_start_in = '0;
               end
            end
         end
         ST_SCORE: begin
            run_in    = step_res.run;
            points_in = points_ff + PTS_W'(step_res.point);
            scan_in   = scan_ff << RUN_BITS;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               verdict.valid = 1'b1;
               verdict.hit   = hit;
               if (hit) begin
                  out_valid_in = 1'b1;
                  out_found_in = 1'b1;
                  out_start_in = job_ff.payload_start;
               end else if (job_ff.last_bit) begin
                  out_valid_in = 1'b1;
                  out_found_in = 1'b0;
                  out_start_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      run_ff       <= run_in;
      points_ff    <= points_in;
      step_ff      <= step_in;
      job_ff       <= job_in;
      out_found_ff <= out_found_in;
      out_start_ff <= out_start_in;
      // score must reach percent * bytes / 100, compared as points * 100
      need_ff      <= CMP_W'(percent) * CMP_W'(BYTES);
   end

endmodule
`default_nettype wire

FILE: rtl/sync_field_search_core.sv
// Sync field search top level: register file, front end, job queue and back end.
//
// Sliding-window sync word search over a bit stream, one bit per req word,
// req_tlast marking the last bit of a frame. A bit that does not complete a
// window to be checked is taken as soon as the job queue has room. A bit that
// completes such a window holds req_tready low until the verdict: the back
// end scores the window one byte of match flags per cycle, carrying the run
// of matching bits from byte to byte, and the front end waits for its
// verdict since the next bit depends on it. A word on rsp carries found in
// tuser and payload_start in tdata; at most one per frame.
// Configuration writes are taken at any time on the csr port but must only
// be issued while the block is idle.
`default_nettype none
`include "sync_field_search_core_defines.svh"
module sync_field_search_core #(
   parameter int SYNC_BITS      = 256,
   parameter int MAX_FRAME_BITS = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata: bit 0 bit_value, bits 7:1 zero
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [sfs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tlast,
   // rsp_tdata: bits 16:0 payload_start, bits 23:17 zero; rsp_tuser: found
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [sfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                           rsp_tuser,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [sfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfs_pkg::PAT_WORD_W-1:0] csr_wdata
);
   import sfs_pkg::*;

   logic [PAT_WORD_W-1:0] pat0_ff, pat0_in;
   logic [PAT_WORD_W-1:0] pat1_ff, pat1_in;
   logic [PAT_WORD_W-1:0] pat2_ff, pat2_in;
   logic [PAT_WORD_W-1:0] pat3_ff, pat3_in;
   logic [PCT_W-1:0]      percent_ff, percent_in;

   logic                 push_valid, push_ready;
   job_type              push_job, pop_job;
   logic                 pop_valid, pop_ready;
   verdict_type          verdict;
   logic [SYNC_BITS-1:0] window;
   logic                 front_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      pat0_in    = pat0_ff;
      pat1_in    = pat1_ff;
      pat2_in    = pat2_ff;
      pat3_in    = pat3_ff;
      percent_in = percent_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PATTERN_0:  pat0_in    = csr_wdata;
            REG_PATTERN_1:  pat1_in    = csr_wdata;
            REG_PATTERN_2:  pat2_in    = csr_wdata;
            REG_PATTERN_3:  pat3_in    = csr_wdata;
            REG_CONFIDENCE: percent_in = csr_wdata[PCT_W-1:0];
            default: begin
               // drop writes to unused indexes
               percent_in = percent_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat0_ff    <= '0;
         pat1_ff    <= '0;
         pat2_ff    <= '0;
         pat3_ff    <= '0;
         percent_ff <= PCT_RESET;
      end else begin
         pat0_ff    <= pat0_in;
         pat1_ff    <= pat1_in;
         pat2_ff    <= pat2_in;
         pat3_ff    <= pat3_in;
         percent_ff <= percent_in;
      end
   end

   sfs_front #(
      .SYNC_BITS      (SYNC_BITS),
      .MAX_FRAME_BITS (MAX_FRAME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .verdict    (verdict),
      .window     (window),
      .busy       (front_busy)
   );

   sfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   sfs_back #(
      .SYNC_BITS (SYNC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .window     (window),
      .pattern    ({pat0_ff, pat1_ff, pat2_ff, pat3_ff}),
      .percent    (percent_ff),
      .verdict    (verdict),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `SFS_ASSERT_IMP(a_notfound_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "not found word with nonzero payload start")
   `SFS_ASSERT_IMP(a_verdict_busy, verdict.valid, front_busy, "verdict with no outstanding check")
   `SFS_ASSERT_IMP(a_queue_space, push_valid, push_ready, "job pushed into a full queue")
   `SFS_ASSERT_NXT(a_busy_holds, front_busy && !verdict.valid, front_busy, "front released without a verdict")

endmodule
`default_nettype wire
